/* rtl/rfi_pkg.sv */
// Shared constants, types and state codes for the RGBA fade interpolator.
// Used by the serial divider, the blend lanes and the top level.
`default_nettype none

package rfi_pkg;

   // Field widths.
   localparam int TIME_WIDTH    = 24;
   localparam int CHANNEL_WIDTH = 8;

   // Fraction elapsed/duration is Q0.16.
   localparam int FRAC_BITS = 16;
   localparam int COUNT_W   = $clog2(FRAC_BITS);

   // Channel order inside a color: red, green, blue, alpha.
   localparam int NUM_CH    = 4;
   localparam int ALPHA_IDX = 3;

   // Accumulator of one blend lane holds (goal - start) * frac, signed.
   localparam int ACC_W = CHANNEL_WIDTH + FRAC_BITS + 1;

   // Packed stream words, rounded up to whole bytes.
   localparam int REQ_FIELDS_W = NUM_CH * CHANNEL_WIDTH + TIME_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = (NUM_CH + 1) * CHANNEL_WIDTH + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [CHANNEL_WIDTH-1:0]             chan_type;
   typedef logic [NUM_CH-1:0][CHANNEL_WIDTH-1:0] color_type;
   typedef logic [TIME_WIDTH-1:0]                time_type;

   localparam chan_type CH_MAX   = {CHANNEL_WIDTH{1'b1}};
   localparam time_type TIME_MAX = {TIME_WIDTH{1'b1}};

   // Item kinds carried on the request tuser bit.
   localparam logic MODE_BEGIN = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_APPLY,
      ST_PUBLISH
   } state_type;

   // Control from the sequencer to the serial datapath units.
   typedef struct packed {
      logic load;
      logic step;
   } serial_ctl_type;

endpackage

`default_nettype wire

/* rtl/rfi_divider.sv */
// Restoring divider that yields one quotient bit per cycle while ctl.step is set, MSB first.
// Depends on rfi_pkg for widths and the control struct.
`default_nettype none

module rfi_divider (
   input  wire                      clock,
   input  wire rfi_pkg::serial_ctl_type ctl,
   input  wire rfi_pkg::time_type   dividend,
   input  wire rfi_pkg::time_type   divisor,
   output logic                     quot_bit
);

   rfi_pkg::time_type              rem_ff;
   rfi_pkg::time_type              rem_in;
   logic [rfi_pkg::TIME_WIDTH:0]   shifted;
   logic [rfi_pkg::TIME_WIDTH:0]   trial;

   // The remainder stays below the divisor, so doubling it fits one extra bit.
   always_comb begin
      shifted  = {rem_ff, 1'b0};
      trial    = shifted - {1'b0, divisor};
      quot_bit = (shifted >= {1'b0, divisor});
      if (ctl.load) begin
         rem_in = dividend;
      end else if (ctl.step) begin
         rem_in = quot_bit ? trial[rfi_pkg::TIME_WIDTH-1:0]
                           : shifted[rfi_pkg::TIME_WIDTH-1:0];
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

endmodule

`default_nettype wire

/* rtl/rfi_blend_lane.sv */
// One channel of the linear blend: accumulates (goal - start) * frac from the
// serial quotient bits, MSB first. Depends on rfi_pkg.
`default_nettype none

module rfi_blend_lane (
   input  wire                      clock,
   input  wire rfi_pkg::serial_ctl_type ctl,
   input  wire rfi_pkg::chan_type   start_val,
   input  wire rfi_pkg::chan_type   goal_val,
   input  wire                      quot_bit,
   output rfi_pkg::chan_type        result
);

   logic signed [rfi_pkg::CHANNEL_WIDTH:0] diff_ff;
   logic signed [rfi_pkg::CHANNEL_WIDTH:0] diff_in;
   logic signed [rfi_pkg::ACC_W-1:0]       acc_ff;
   logic signed [rfi_pkg::ACC_W-1:0]       acc_in;
   logic signed [rfi_pkg::ACC_W-1:0]       addend;
   logic [rfi_pkg::CHANNEL_WIDTH:0]        sum;

   always_comb begin
      addend = quot_bit
             ? {{(rfi_pkg::ACC_W-rfi_pkg::CHANNEL_WIDTH-1){diff_ff[rfi_pkg::CHANNEL_WIDTH]}},
                diff_ff}
             : '0;
      if (ctl.load) begin
         diff_in = {1'b0, goal_val} - {1'b0, start_val};
         acc_in  = '0;
      end else if (ctl.step) begin
         diff_in = diff_ff;
         acc_in  = (acc_ff <<< 1) + addend;
      end else begin
         diff_in = diff_ff;
         acc_in  = acc_ff;
      end
      // The upper slice of the signed product is its floor over 2^16.
      sum    = {1'b0, start_val}
             + acc_ff[rfi_pkg::ACC_W-1:rfi_pkg::FRAC_BITS];
      result = sum[rfi_pkg::CHANNEL_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
   end

endmodule

`default_nettype wire

/* rtl/rgba_fade_interpolator_top.sv */
// Top level of the RGBA fade interpolator: sequencer, fade state and stream ports.
// Depends on rfi_pkg, rfi_divider and rfi_blend_lane.
//
// Each request word either begins a fade (tuser = 0) toward a target color over a
// duration, or advances a running fade by a number of ticks (tuser = 1), and each
// produces exactly one response word with the color, modulation and status after
// that step. While a fade is in progress an item goes through accept, evaluate, the
// bit-serial division elapsed/duration, whose quotient bits feed four shift-and-add
// blend lanes in the same cycles, apply and publish. A tick while idle, or the step
// that ends a fade, goes from accept through evaluate straight to publish. The
// response sits in an output register; the next request is taken as soon as the
// sequencer is back in idle, even while that response still waits for rsp_tready,
// and a new response is only loaded once the previous one has gone.
`default_nettype none

module rgba_fade_interpolator_top (
   input  wire                              clock,
   input  wire                              reset,
   // Request stream.
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tdata from bit 0 up: target_red, target_green, target_blue, target_alpha,
   // time_value.
   input  wire [rfi_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: mode.
   input  wire                              req_tuser,
   // Response stream.
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata from bit 0 up: color_red, color_green, color_blue, color_alpha,
   // modulation, overlay_active, fade_busy, zero fill.
   output logic [rfi_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CW = rfi_pkg::CHANNEL_WIDTH;
   localparam int TW = rfi_pkg::TIME_WIDTH;

   rfi_pkg::state_type          state_ff, state_in;
   rfi_pkg::color_type          present_ff, present_in;
   rfi_pkg::color_type          start_ff, start_in;
   rfi_pkg::color_type          goal_ff, goal_in;
   rfi_pkg::time_type           elapsed_ff, elapsed_in;
   rfi_pkg::time_type           duration_ff, duration_in;
   rfi_pkg::time_type           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        overlay_ff, overlay_in;
   logic                        lerp_ff, lerp_in;
   rfi_pkg::chan_type           mod_ff, mod_in;
   logic [rfi_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rfi_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   rfi_pkg::serial_ctl_type     ctl;
   logic                        quot_bit;
   rfi_pkg::color_type          lane_result;

   rfi_pkg::color_type          target;
   rfi_pkg::time_type           time_value;
   logic                        accept;
   logic                        start_rgb_zero;
   logic                        target_rgb_zero;
   logic                        goal_rgb_zero;
   logic [TW:0]                 elapsed_sum;
   logic                        can_publish;

   // Unpack the request word.
   always_comb begin
      for (int c = 0; c < rfi_pkg::NUM_CH; c++) begin
         target[c] = req_tdata[c*CW +: CW];
      end
      time_value = req_tdata[rfi_pkg::NUM_CH*CW +: TW];
   end

   assign req_tready = (state_ff == rfi_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rfi_divider u_divider (
      .clock    (clock),
      .ctl      (ctl),
      .dividend (elapsed_ff),
      .divisor  (duration_ff),
      .quot_bit (quot_bit)
   );

   for (genvar c = 0; c < rfi_pkg::NUM_CH; c++) begin : g_lane
      rfi_blend_lane u_lane (
         .clock     (clock),
         .ctl       (ctl),
         .start_val (start_ff[c]),
         .goal_val  (goal_ff[c]),
         .quot_bit  (quot_bit),
         .result    (lane_result[c])
      );
   end

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      elapsed_in   = elapsed_ff;
      duration_in  = duration_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      overlay_in   = overlay_ff;
      lerp_in      = lerp_ff;
      mod_in       = mod_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctl          = '0;

      start_rgb_zero  = (present_ff[0] == '0) && (present_ff[1] == '0)
                     && (present_ff[2] == '0);
      target_rgb_zero = (target[0] == '0) && (target[1] == '0) && (target[2] == '0);
      goal_rgb_zero   = (goal_ff[0] == '0) && (goal_ff[1] == '0) && (goal_ff[2] == '0);
      elapsed_sum     = {1'b0, elapsed_ff} + {1'b0, step_ff};
      can_publish     = !rsp_valid_ff || rsp_tready;

      unique case (state_ff)
         rfi_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rfi_pkg::ST_EVAL;
               if (req_tuser == rfi_pkg::MODE_BEGIN) begin
                  // Begin: the present color becomes the start of the fade.
                  busy_in     = 1'b1;
                  duration_in = time_value;
                  elapsed_in  = '0;
                  step_in     = '0;
                  start_in    = present_ff;
                  goal_in     = target;
                  overlay_in  = !(start_rgb_zero && target_rgb_zero);
                  if (!(start_rgb_zero && target_rgb_zero)) begin
                     mod_in = rfi_pkg::CH_MAX;
                  end
                  // RGB is held when either end is fully transparent.
                  if (target[rfi_pkg::ALPHA_IDX] == '0) begin
                     lerp_in = 1'b0;
                  end else if (present_ff[rfi_pkg::ALPHA_IDX] == '0) begin
                     lerp_in = 1'b0;
                     for (int c = 0; c < rfi_pkg::ALPHA_IDX; c++) begin
                        present_in[c] = target[c];
                     end
                  end else begin
                     lerp_in = 1'b1;
                  end
               end else begin
                  step_in = time_value;
               end
            end
         end

         rfi_pkg::ST_EVAL: begin
            if (!busy_ff) begin
               state_in = rfi_pkg::ST_PUBLISH;
            end else if (elapsed_ff >= duration_ff) begin
               // The fade has run its course: land on the goal.
               state_in   = rfi_pkg::ST_PUBLISH;
               present_in = goal_ff;
               busy_in    = 1'b0;
               if (!overlay_ff) begin
                  mod_in = rfi_pkg::CH_MAX - goal_ff[rfi_pkg::ALPHA_IDX];
               end else if ((goal_ff[rfi_pkg::ALPHA_IDX] == '0) || goal_rgb_zero) begin
                  overlay_in = 1'b0;
                  mod_in     = rfi_pkg::CH_MAX - goal_ff[rfi_pkg::ALPHA_IDX];
               end
            end else begin
               state_in = rfi_pkg::ST_DIVIDE;
               ctl.load = 1'b1;
               count_in = '0;
            end
         end

         rfi_pkg::ST_DIVIDE: begin
            ctl.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == rfi_pkg::COUNT_W'(rfi_pkg::FRAC_BITS - 1)) begin
               state_in = rfi_pkg::ST_APPLY;
            end
         end

         rfi_pkg::ST_APPLY: begin
            state_in = rfi_pkg::ST_PUBLISH;
            present_in[rfi_pkg::ALPHA_IDX] = lane_result[rfi_pkg::ALPHA_IDX];
            if (lerp_ff) begin
               for (int c = 0; c < rfi_pkg::ALPHA_IDX; c++) begin
                  present_in[c] = lane_result[c];
               end
            end
            if (!overlay_ff) begin
               mod_in = rfi_pkg::CH_MAX - lane_result[rfi_pkg::ALPHA_IDX];
            end
            // Elapsed time saturates at the top of its range.
            elapsed_in = elapsed_sum[TW] ? rfi_pkg::TIME_MAX : elapsed_sum[TW-1:0];
         end

         rfi_pkg::ST_PUBLISH: begin
            if (can_publish) begin
               state_in     = rfi_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               for (int c = 0; c < rfi_pkg::NUM_CH; c++) begin
                  rsp_data_in[c*CW +: CW] = present_ff[c];
               end
               rsp_data_in[rfi_pkg::NUM_CH*CW +: CW]     = mod_ff;
               rsp_data_in[(rfi_pkg::NUM_CH+1)*CW]       = overlay_ff;
               rsp_data_in[(rfi_pkg::NUM_CH+1)*CW + 1]   = busy_ff;
            end
         end

         default: begin
            state_in = rfi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfi_pkg::ST_IDLE;
         present_ff   <= '0;
         start_ff     <= '0;
         goal_ff      <= '0;
         elapsed_ff   <= '0;
         duration_ff  <= '0;
         step_ff      <= '0;
         busy_ff      <= 1'b0;
         overlay_ff   <= 1'b0;
         lerp_ff      <= 1'b0;
         mod_ff       <= rfi_pkg::CH_MAX;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         elapsed_ff   <= elapsed_in;
         duration_ff  <= duration_in;
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         overlay_ff   <= overlay_in;
         lerp_ff      <= lerp_in;
         mod_ff       <= mod_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response payload needs no reset; its valid flag guards it.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
